// ----- hdl/fbt_pkg.sv -----
// Package: shared constants, types and codes for the leaf-depth tree builder.
`timescale 1ns / 1ps

package fbt_pkg;

	localparam int MAX_DEPTH  = 32;
	localparam int MAX_LEAVES = 65536;

	localparam int ID_W    = 17;
	localparam int DEPTH_W = 6;
	localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W   = $clog2(MAX_DEPTH);

	localparam int ID_CAP    = (2 ** ID_W) - 1;
	localparam int LIMIT_RAW = 2 * MAX_LEAVES - 1;
	localparam int ID_LIMIT  = (LIMIT_RAW > ID_CAP) ? ID_CAP : LIMIT_RAW;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHALLOW  = 2'd1,
		ST_DEEP     = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ROOT,
		S_NODE,
		S_FILL
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    node;
		logic [DEPTH_W-1:0] level;
		logic               left_done;
	} entry_t;

	typedef struct packed {
		logic [ID_W-1:0] node_id;
		logic [ID_W-1:0] parent_id;
		logic            is_leaf;
		logic            tree_done;
		status_t         status;
		logic            last;
	} res_t;

endpackage

// ----- hdl/fbt_if.sv -----
// Interfaces: leaf-depth input channel and node result channel.
`timescale 1ns / 1ps

interface fbt_leaf_if
	import fbt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] leaf_depth;

	modport source (output valid, output leaf_depth, input ready);
	modport sink (input valid, input leaf_depth, output ready);
endinterface

interface fbt_node_if
	import fbt_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] node_id;
	logic [ID_W-1:0] parent_id;
	logic            is_leaf;
	logic            tree_done;
	status_t         status;
	logic            last;

	modport source (output valid, output node_id, output parent_id, output is_leaf,
		output tree_done, output status, output last, input ready);
	modport sink (input valid, input node_id, input parent_id, input is_leaf,
		input tree_done, input status, input last, output ready);
endinterface

// ----- hdl/full_binary_tree_from_leaf_depths_core.sv -----
// Top level: builds a full binary tree in preorder from a stream of leaf depths.
`timescale 1ns / 1ps

// Usage
//   leaf: one beat per leaf, leftmost leaf first, carrying its depth (root = 0).
//   node: one beat per created node, in preorder, with its parent id. The first
//   leaf of a tree yields the root first; every leaf yields the internal nodes
//   down to depth-1 and then the leaf itself, whose beat has last set. A bad
//   depth yields one beat with a nonzero status, zero ids and last set, and
//   leaves the state untouched. tree_done marks the leaf that closes the tree;
//   the next leaf starts a new tree numbered from 1 again.
// Timing
//   A good leaf is taken in S_IDLE and checked in S_CHECK, then one node
//   per cycle goes into the node register unless the node channel stalls.
//   A bad depth's beat leaves from S_CHECK.
//   A leaf that closes a subtree while the tree stays open then passes through
//   S_FILL, which loads the top-of-stack register from the stack memory (one
//   read port, registered read). The next leaf is taken once the last node is in
//   the output register and any refill is done, even if that beat still waits.
// Reset and stall
//   arst_n clears the stack (empty) and restarts numbering at 1. A stalled
//   node channel holds the output beat and freezes the build in place.
module full_binary_tree_from_leaf_depths_core
	import fbt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	fbt_leaf_if.sink        leaf,
	fbt_node_if.source      node
);

	// Stack of open internal nodes below the top; the top lives in top_q.
	entry_t mem [MAX_DEPTH];
	entry_t rd_q;

	state_t             state_q, state_nx;
	logic [CNT_W-1:0]   count_q;
	// One bit wider than an id, so running past the last id is seen as overflow.
	logic [ID_W:0]      next_id_q;
	logic [DEPTH_W-1:0] d_q;
	entry_t             top_q;

	logic out_valid_q;
	res_t res_q;

	// Decode
	logic               slot_free;
	logic               fresh;
	logic [DEPTH_W-1:0] top_depth;
	logic               shallow, deep, overflow, bad;
	logic [DEPTH_W:0]   nnew;
	logic [ID_W:0]      id_end;
	logic               at_leaf;
	logic               closes_tree;
	logic [CNT_W-1:0]   cnt_m1, cnt_m2;

	// Control outputs of the sequencer
	logic             take;
	logic             emit;
	res_t             res;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	assign slot_free = !out_valid_q || node.ready;
	assign fresh     = (count_q == '0);
	assign top_depth = fresh ? '0 : top_q.level;
	assign shallow   = ({1'b0, d_q} < ({1'b0, top_depth} + (DEPTH_W+1)'(1)));
	assign deep      = (d_q > DEPTH_W'(MAX_DEPTH));
	assign nnew      = (DEPTH_W+1)'(fresh) + {1'b0, d_q} - {1'b0, top_depth};
	assign id_end    = next_id_q + (ID_W+1)'(nnew) - (ID_W+1)'(1);
	assign overflow  = (id_end > (ID_W+1)'(ID_LIMIT));
	assign bad       = shallow || deep || overflow;
	assign at_leaf   = (({1'b0, top_q.level} + (DEPTH_W+1)'(1)) == {1'b0, d_q});
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_m2    = count_q - CNT_W'(2);
	assign closes_tree = at_leaf && top_q.left_done && (count_q == CNT_W'(1));

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (leaf.valid) state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (bad) begin
					if (slot_free) state_nx = S_IDLE;
				end else if (fresh) begin
					state_nx = S_ROOT;
				end else begin
					state_nx = S_NODE;
				end
			end
			S_ROOT: begin
				if (slot_free) state_nx = S_NODE;
			end
			S_NODE: begin
				if (slot_free && at_leaf) begin
					if (top_q.left_done && !closes_tree) state_nx = S_FILL;
					else state_nx = S_IDLE;
				end
			end
			S_FILL: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		take    = 1'b0;
		emit    = 1'b0;
		res     = '0;
		wr_en   = 1'b0;
		wr_addr = cnt_m1[IDX_W-1:0];
		wr_data = top_q;
		wr_data.left_done = 1'b1;
		rd_en   = 1'b0;
		rd_addr = cnt_m2[IDX_W-1:0];
		case (state_q)
			S_IDLE: take = 1'b1;
			S_CHECK: begin
				if (bad) begin
					emit     = slot_free;
					res.last = 1'b1;
					if (shallow)   res.status = ST_SHALLOW;
					else if (deep) res.status = ST_DEEP;
					else           res.status = ST_OVERFLOW;
				end
			end
			S_ROOT: begin
				emit        = slot_free;
				res.node_id = next_id_q[ID_W-1:0];
			end
			S_NODE: begin
				emit          = slot_free;
				res.node_id   = next_id_q[ID_W-1:0];
				res.parent_id = top_q.node;
				res.is_leaf   = at_leaf;
				res.tree_done = closes_tree;
				res.last      = at_leaf;
				// Push the open parent before its first child replaces the top.
				wr_en = slot_free && !at_leaf && !top_q.left_done;
				// Pop: fetch the entry under the top.
				rd_en = slot_free && at_leaf && top_q.left_done && !closes_tree;
			end
			default: ;
		endcase
	end

	assign leaf.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_id_q   <= (ID_W+1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) out_valid_q <= 1'b1;
			else if (node.ready) out_valid_q <= 1'b0;
			if (state_q == S_ROOT && slot_free) begin
				count_q   <= CNT_W'(1);
				next_id_q <= next_id_q + (ID_W+1)'(1);
			end
			if (state_q == S_NODE && slot_free) begin
				next_id_q <= closes_tree ? (ID_W+1)'(1) : next_id_q + (ID_W+1)'(1);
				if (!at_leaf && !top_q.left_done) count_q <= count_q + CNT_W'(1);
				if (at_leaf && top_q.left_done) count_q <= cnt_m1;
			end
		end
	end

	// Payload registers: depth, top of stack, output beat
	always_ff @(posedge clk) begin
		if (take && leaf.valid) d_q <= leaf.leaf_depth;
		if (emit) res_q <= res;
		case (state_q)
			S_ROOT: begin
				if (slot_free) top_q <= '{node: next_id_q[ID_W-1:0], level: '0,
					left_done: 1'b0};
			end
			S_NODE: begin
				if (slot_free) begin
					if (!at_leaf) begin
						top_q <= '{node: next_id_q[ID_W-1:0],
							level: top_q.level + DEPTH_W'(1), left_done: 1'b0};
					end else if (!top_q.left_done) begin
						top_q.left_done <= 1'b1;
					end
				end
			end
			S_FILL: top_q <= rd_q;
			default: ;
		endcase
	end

	// Stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign node.valid     = out_valid_q;
	assign node.node_id   = res_q.node_id;
	assign node.parent_id = res_q.parent_id;
	assign node.is_leaf   = res_q.is_leaf;
	assign node.tree_done = res_q.tree_done;
	assign node.status    = res_q.status;
	assign node.last      = res_q.last;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DEPTH))
		else $error("stack count beyond capacity");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("node numbering hit zero");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_OK |-> res_q.last && res_q.node_id == '0)
		else $error("error beat not final or carries an id");

	a_fill_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> $past(rd_en))
		else $error("refill without a stack read");

	a_done_resets: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.tree_done |=> count_q == '0 && next_id_q == (ID_W+1)'(1))
		else $error("tree completion left state behind");
`endif

endmodule
